FILE: hdl/art_pkg.sv
// art_pkg: opcodes, status codes and the token that walks the cell chain
// of the address range table. No dependencies.
`timescale 1ns / 1ps

package art_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;
  localparam logic [OP_W-1:0] OP_CONFLICT = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One transaction in flight, with its partial result.
  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [SLOT_W-1:0] entry_slot;
    logic              found;
    logic [SLOT_W-1:0] slot_used;
    logic [STAT_W-1:0] status;
  } tok_t;

endpackage

FILE: hdl/art_if.sv
// art_if: valid/ready channel interfaces for the address range table.
// Depends on art_pkg for field widths.
`timescale 1ns / 1ps

interface art_in_if;
  logic                        valid;
  logic                        ready;
  logic [art_pkg::OP_W-1:0]    opcode;
  logic [art_pkg::ADDR_W-1:0]  range_start;
  logic [art_pkg::ADDR_W-1:0]  range_end;
  logic [art_pkg::SLOT_W-1:0]  entry_slot;

  modport source (output valid, opcode, range_start, range_end, entry_slot, input ready);
  modport sink   (input valid, opcode, range_start, range_end, entry_slot, output ready);
endinterface

interface art_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [art_pkg::SLOT_W-1:0]  slot_used;
  logic [art_pkg::STAT_W-1:0]  status;

  modport source (output valid, found, slot_used, status, input ready);
  modport sink   (input valid, found, slot_used, status, output ready);
endinterface

FILE: hdl/art_cell.sv
// art_cell: one table entry plus one token stage of the chain.
// Depends on art_pkg.
`timescale 1ns / 1ps

module art_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  art_pkg::tok_t tok_in,
  output art_pkg::tok_t tok_out
);

  // Slots past the 4-bit field can never be named by a delete.
  localparam logic                     IDX_FITS = (IDX < (1 << art_pkg::SLOT_W));
  localparam logic [art_pkg::SLOT_W-1:0] IDX_SLOT = art_pkg::SLOT_W'(IDX);

  logic [art_pkg::ADDR_W-1:0] low_r, high_r;
  logic                       valid_r, valid_nxt;
  logic                       claim;
  logic                       hit_s, hit_e, encl;
  art_pkg::tok_t              tok_r, tok_nxt;

  assign hit_s = (tok_in.range_start >= low_r) && (tok_in.range_start <= high_r);
  assign hit_e = (tok_in.range_end >= low_r) && (tok_in.range_end <= high_r);
  assign encl  = (tok_in.range_start < low_r) && (tok_in.range_end > high_r);

  always_comb begin
    tok_nxt   = tok_in;
    valid_nxt = valid_r;
    claim     = 1'b0;
    case (tok_in.opcode)
      art_pkg::OP_ADD: begin
        // first free cell on the path takes the range
        if (tok_in.vld && !valid_r && tok_in.status == art_pkg::ST_FULL) begin
          claim             = 1'b1;
          valid_nxt         = 1'b1;
          tok_nxt.status    = art_pkg::ST_OK;
          tok_nxt.slot_used = IDX_SLOT;
        end
      end
      art_pkg::OP_DELETE: begin
        if (tok_in.vld && IDX_FITS && tok_in.entry_slot == IDX_SLOT && valid_r) begin
          valid_nxt      = 1'b0;
          tok_nxt.status = art_pkg::ST_OK;
        end
      end
      art_pkg::OP_LOOKUP: begin
        tok_nxt.found = tok_in.found | (valid_r & hit_s);
      end
      art_pkg::OP_CONFLICT: begin
        tok_nxt.found = tok_in.found | (valid_r & (hit_s | hit_e | encl));
      end
      default: begin
        tok_nxt = tok_in;
      end
    endcase
  end

  // Control bits reset; payload and bounds only load on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (advance) begin
      tok_r.vld <= tok_in.vld;
      if (tok_in.vld) begin
        valid_r <= valid_nxt;
      end
    end
    if (advance) begin
      tok_r.opcode      <= tok_nxt.opcode;
      tok_r.range_start <= tok_nxt.range_start;
      tok_r.range_end   <= tok_nxt.range_end;
      tok_r.entry_slot  <= tok_nxt.entry_slot;
      tok_r.found       <= tok_nxt.found;
      tok_r.slot_used   <= tok_nxt.slot_used;
      tok_r.status      <= tok_nxt.status;
      if (claim) begin
        low_r  <= tok_in.range_start;
        high_r <= tok_in.range_end;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hdl/address_range_table.sv
// address_range_table: top level, a chain of ENTRIES art_cell stages.
// Depends on art_pkg, art_if (art_in_if, art_out_if) and art_cell.
`timescale 1ns / 1ps
//
//  channel   | dir | payload                                    | transaction
//  ----------+-----+--------------------------------------------+------------------
//  in_chan   | in  | opcode, range_start, range_end, entry_slot | valid && ready
//  out_chan  | out | found, slot_used, status                   | valid && ready
//
//  A transaction walks the cell row one entry per cycle while the row is not
//  frozen, and its result leaves the register of the last cell. A new
//  transaction may enter every cycle unless the row is frozen, so the row
//  holds up to ENTRIES in flight. Reset (rst_n low, synchronous) clears every
//  entry's valid bit and empties the row; stored bounds are not reset.
//  A result held at out_chan with ready low freezes the whole row, and in_chan
//  ready drops with it.

module address_range_table #(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  art_in_if.sink    in_chan,
  art_out_if.source out_chan
);

  art_pkg::tok_t chain [ENTRIES+1];
  logic          advance;

  // Row moves unless the last stage holds an untaken result.
  assign advance       = !chain[ENTRIES].vld || out_chan.ready;
  assign in_chan.ready = advance;

  // Token entry: add starts as "full" and delete as "empty"; a cell that
  // stores or frees the entry turns it to ok on the way through.
  always_comb begin
    chain[0].vld         = in_chan.valid;
    chain[0].opcode      = in_chan.opcode;
    chain[0].range_start = in_chan.range_start;
    chain[0].range_end   = in_chan.range_end;
    chain[0].entry_slot  = in_chan.entry_slot;
    chain[0].found       = 1'b0;
    chain[0].slot_used   = '0;
    case (in_chan.opcode)
      art_pkg::OP_ADD:    chain[0].status = art_pkg::ST_FULL;
      art_pkg::OP_DELETE: chain[0].status = art_pkg::ST_EMPTY;
      default:            chain[0].status = art_pkg::ST_OK;
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    art_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // Last cell's token register doubles as the output register.
  assign out_chan.valid     = chain[ENTRIES].vld;
  assign out_chan.found     = chain[ENTRIES].found;
  assign out_chan.slot_used = chain[ENTRIES].slot_used;
  assign out_chan.status    = chain[ENTRIES].status;

  // A stalled result must hold the input side off.
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while result stalled");

  // Failed add or delete carries no slot and no hit.
  a_fail_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == art_pkg::ST_FULL ||
                        out_chan.status == art_pkg::ST_EMPTY))
    |-> (out_chan.slot_used == '0 && !out_chan.found))
    else $error("failed add/delete with slot or hit set");

  // Reset empties the row.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result present right after reset");

endmodule
